// ===== design/sm7pwm_pkg.sv =====
// Shared constants for the sliding median filter and PWM duty block.
package sm7pwm_pkg;

    // Default window length and sample width
    localparam int WINDOW_LEN_DEF  = 7;
    localparam int SAMPLE_BITS_DEF = 12;

    // Duty = floor(median * DUTY_MUL / DUTY_DIV)
    localparam int DUTY_MUL = 7;
    localparam int DUTY_DIV = 10;

    // Extra product bits needed to hold median * DUTY_MUL
    localparam int DUTY_MUL_BITS = 3;

    // Valid flag and window-full flag that travel with a word down the pipe
    typedef struct packed {
        logic valid;
        logic full;
    } stage_ctl_t;

endpackage

// ===== design/sm7pwm_ifs.sv =====
// Valid/ready channel interfaces for the sample and result words.

interface sm7pwm_sample_if #(
    parameter int SAMPLE_BITS = sm7pwm_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface sm7pwm_result_if #(
    parameter int SAMPLE_BITS = sm7pwm_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] median;
    logic [SAMPLE_BITS-1:0] duty;
    logic                   window_full;

    modport source (output valid, output median, output duty, output window_full,
                    input ready);
    modport sink   (input valid, input median, input duty, input window_full,
                    output ready);
endinterface

// ===== design/sliding_median7_to_pwm_duty.sv =====
// Top level: sliding-window median filter with PWM duty output.
//
// Usage:
//   samples : sink channel, one converter sample per word.
//   results : source channel, one word per sample: median of the last WINDOW_LEN
//             samples (0 until the window has filled), duty = floor(median*7/10),
//             and window_full, set from the WINDOW_LEN-th sample on.
//   Equal-length windows (even WINDOW_LEN) take the upper middle element.
// Timing:
//   Three-stage pipeline: window shift line, median select, duty multiply.
//   A sample enters the window line, its median the median register and its
//   duty the output register; one sample per cycle while results.ready holds.
//   The rank network from window taps to median register sets the clock period.
// Reset:
//   rst_n clears all pipeline valids, the fill count and the full flag; the
//   window contents are only used once every tap has been written.
// Backpressure:
//   Each stage advances when empty or when the next stage moves, so a stalled
//   receiver fills the pipe first; samples are taken until all stages are full.
module sliding_median7_to_pwm_duty #(
    parameter int WINDOW_LEN  = sm7pwm_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = sm7pwm_pkg::SAMPLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    sm7pwm_sample_if.sink      samples,
    sm7pwm_result_if.source    results
);
    import sm7pwm_pkg::*;

    localparam int CNT_BITS  = $clog2(WINDOW_LEN);
    localparam int Y_BITS    = SAMPLE_BITS + DUTY_MUL_BITS;
    localparam int SHIFT     = Y_BITS + 3;
    localparam int RECIP     = ((2 ** SHIFT) + DUTY_DIV - 1) / DUTY_DIV;
    localparam int K_BITS    = SHIFT - 2;
    localparam int PROD_BITS = Y_BITS + K_BITS;

    // Window shift line and fill tracking
    logic [SAMPLE_BITS-1:0] window_reg [WINDOW_LEN];
    logic [CNT_BITS-1:0]    fill_cnt_reg;
    logic                   filled_reg;

    // Pipeline registers
    stage_ctl_t             s1_ctl_reg;
    stage_ctl_t             s2_ctl_reg;
    logic [SAMPLE_BITS-1:0] s2_median_reg;
    stage_ctl_t             out_ctl_reg;
    logic [SAMPLE_BITS-1:0] out_median_reg;
    logic [SAMPLE_BITS-1:0] out_duty_reg;

    logic                   out_ready;
    logic                   s2_ready;
    logic                   s1_ready;
    logic                   accept;
    logic                   item_full;
    logic [SAMPLE_BITS-1:0] median_sel;
    logic [SAMPLE_BITS-1:0] median_next;
    logic [Y_BITS-1:0]      scaled;
    logic [PROD_BITS-1:0]   prod;
    logic [SAMPLE_BITS-1:0] duty_next;

    // Per-stage ready: a stage can load when empty or when it is moving on
    assign out_ready = !out_ctl_reg.valid || results.ready;
    assign s2_ready  = !s2_ctl_reg.valid || out_ready;
    assign s1_ready  = !s1_ctl_reg.valid || s2_ready;

    assign samples.ready = s1_ready;
    assign accept        = samples.valid && s1_ready;

    // This sample sees a full window when the window was already filled or it lands in the last free tap
    assign item_full = filled_reg || (fill_cnt_reg == CNT_BITS'(WINDOW_LEN - 1));

    // Fill count and full flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
            filled_reg   <= 1'b0;
        end
        else if (accept && !filled_reg)
        begin
            if (fill_cnt_reg == CNT_BITS'(WINDOW_LEN - 1))
            begin
                filled_reg <= 1'b1;
            end
            else
            begin
                fill_cnt_reg <= fill_cnt_reg + CNT_BITS'(1);
            end
        end
    end

    // Window shift line, newest sample at tap 0
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg[0] <= samples.sample;
            for (int k = 1; k < WINDOW_LEN; k++)
            begin
                window_reg[k] <= window_reg[k-1];
            end
        end
    end

    // Median of the current window
    sm7pwm_median #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_median (
        .taps   (window_reg),
        .median (median_sel)
    );

    assign median_next = s1_ctl_reg.full ? median_sel : '0;

    // Duty: median*7 then divide by 10 through a reciprocal multiply
    assign scaled    = Y_BITS'(s2_median_reg) * Y_BITS'(DUTY_MUL);
    assign prod      = PROD_BITS'(scaled) * PROD_BITS'(RECIP);
    assign duty_next = prod[SHIFT +: SAMPLE_BITS];

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg  <= '0;
            s2_ctl_reg  <= '0;
            out_ctl_reg <= '0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_ctl_reg.valid <= samples.valid;
                s1_ctl_reg.full  <= item_full;
            end
            if (s2_ready)
            begin
                s2_ctl_reg <= s1_ctl_reg;
            end
            if (out_ready)
            begin
                out_ctl_reg <= s2_ctl_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_ctl_reg.valid)
        begin
            s2_median_reg <= median_next;
        end
        if (out_ready && s2_ctl_reg.valid)
        begin
            out_median_reg <= s2_median_reg;
            out_duty_reg   <= duty_next;
        end
    end

    // Result word
    assign results.valid       = out_ctl_reg.valid;
    assign results.median      = out_median_reg;
    assign results.duty        = out_duty_reg;
    assign results.window_full = out_ctl_reg.full;

endmodule

// ===== design/sm7pwm_median.sv =====
// Rank-select median of the window taps: every tap is ranked against all others in parallel.
module sm7pwm_median #(
    parameter int WINDOW_LEN  = sm7pwm_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = sm7pwm_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0] taps [WINDOW_LEN],
    output logic [SAMPLE_BITS-1:0] median
);
    import sm7pwm_pkg::*;

    localparam int RANK_BITS = $clog2(WINDOW_LEN);
    localparam int MID       = WINDOW_LEN / 2;

    logic [RANK_BITS-1:0] rank [WINDOW_LEN];

    // Rank of each tap in ascending order; equal values are split by tap index
    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_LEN; j++)
            begin
                if (j != i)
                begin
                    if ((taps[j] < taps[i]) || ((taps[j] == taps[i]) && (j < i)))
                    begin
                        rank[i] = rank[i] + RANK_BITS'(1);
                    end
                end
            end
        end
    end

    // Ranks form a permutation, so exactly one tap sits at the middle rank
    always_comb
    begin
        median = '0;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            if (rank[i] == RANK_BITS'(MID))
            begin
                median = median | taps[i];
            end
        end
    end

endmodule
